// File: design/bsc_pkg.sv
`timescale 1ns / 1ps

package bsc_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 128;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

  // Stream widths
  localparam int IN_W  = 16;  // char_in, start_of_text
  localparam int OUT_W = 64;  // line_status, offending_char, line_points, total_score, ovf

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_W_ROUND  = 2'd0,
    CFG_W_SQUARE = 2'd1,
    CFG_W_CURLY  = 2'd2,
    CFG_W_ANGLE  = 2'd3
  } cfg_idx_t;

  localparam logic [15:0] W_ROUND_RST  = 16'd3;
  localparam logic [15:0] W_SQUARE_RST = 16'd57;
  localparam logic [15:0] W_CURLY_RST  = 16'd1197;
  localparam logic [15:0] W_ANGLE_RST  = 16'd25137;

  // Bracket kinds as stored on the stack
  typedef enum logic [1:0] {
    BR_ROUND  = 2'd0,
    BR_SQUARE = 2'd1,
    BR_CURLY  = 2'd2,
    BR_ANGLE  = 2'd3
  } br_type_t;

  typedef enum logic [1:0] {
    ST_VALID      = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_CORRUPT    = 2'd2
  } line_status_t;

  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_OPEN_R  = 8'h28;
  localparam logic [7:0] CH_OPEN_S  = 8'h5B;
  localparam logic [7:0] CH_OPEN_C  = 8'h7B;
  localparam logic [7:0] CH_OPEN_A  = 8'h3C;
  localparam logic [7:0] CH_CLOSE_R = 8'h29;
  localparam logic [7:0] CH_CLOSE_S = 8'h5D;
  localparam logic [7:0] CH_CLOSE_C = 8'h7D;
  localparam logic [7:0] CH_CLOSE_A = 8'h3E;

endpackage

// File: design/bracket_syntax_checker.sv
`timescale 1ns / 1ps

// Bracket nesting checker. Takes one text byte per beat and sustains one beat
// per clock; a newline beat yields its result on out_* in the cycle after it is
// accepted, held in an output register. Input beats keep flowing while that
// register is empty or its result is being taken in the same cycle; in_tready
// drops for as long as a held result is not taken, whatever the next byte is.
// Open brackets are kept on a STACK_DEPTH x 2-bit stack in a single memory with
// one write port and a registered read; the top entry lives in a register and
// the entry below it is prefetched every cycle, so a push or pop completes in
// each cycle. No clearing pass is needed after reset. Weights must be written
// on cfg_* only while no beat is in flight; the block does not enforce this.
module bracket_syntax_checker import bsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // [7:0] char_in, [8] start_of_text, rest 0
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // [1:0] line_status, [9:2] offending_char,
                                            // [25:10] line_points, [57:26] total_score,
                                            // [58] depth_overflow, rest 0
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [1:0] stack_mem [STACK_DEPTH];

  logic [15:0] w_round_r, w_square_r, w_curly_r, w_angle_r;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             corrupt_r, corrupt_nxt;
  logic [7:0]       bad_r, bad_nxt;
  logic             ovf_r, ovf_nxt;
  logic [31:0]      sum_r, sum_nxt;
  logic [1:0]       top_r, top_nxt;
  logic [1:0]       below_r;

  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  logic              in_fire;
  logic [7:0]        ch;
  logic              start;
  logic [CNT_W-1:0]  cnt_e;
  logic              corrupt_e;
  logic [7:0]        bad_e;
  logic              ovf_e;
  logic [31:0]       sum_e;
  logic              is_open, is_close;
  logic [1:0]        open_ty, close_ty;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [CNT_W-1:0]  rd_cnt;
  logic [15:0]       pts;
  logic [32:0]       sum_add;
  logic [31:0]       sum_sat;
  logic [1:0]        status;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign ch    = in_tdata[7:0];
  assign start = in_tdata[8];

  // start_of_text clears line state and total before the byte is handled
  assign cnt_e     = start ? '0 : cnt_r;
  assign corrupt_e = start ? 1'b0 : corrupt_r;
  assign bad_e     = start ? 8'h00 : bad_r;
  assign ovf_e     = start ? 1'b0 : ovf_r;
  assign sum_e     = start ? 32'h0 : sum_r;

  always_comb begin
    is_open = 1'b1;
    open_ty = BR_ROUND;
    unique case (ch)
      CH_OPEN_R: open_ty = BR_ROUND;
      CH_OPEN_S: open_ty = BR_SQUARE;
      CH_OPEN_C: open_ty = BR_CURLY;
      CH_OPEN_A: open_ty = BR_ANGLE;
      default:   is_open = 1'b0;
    endcase
  end

  always_comb begin
    is_close = 1'b1;
    close_ty = BR_ROUND;
    unique case (ch)
      CH_CLOSE_R: close_ty = BR_ROUND;
      CH_CLOSE_S: close_ty = BR_SQUARE;
      CH_CLOSE_C: close_ty = BR_CURLY;
      CH_CLOSE_A: close_ty = BR_ANGLE;
      default:    is_close = 1'b0;
    endcase
  end

  always_comb begin
    unique case (bad_e)
      CH_CLOSE_R: pts = w_round_r;
      CH_CLOSE_S: pts = w_square_r;
      CH_CLOSE_C: pts = w_curly_r;
      CH_CLOSE_A: pts = w_angle_r;
      default:    pts = 16'h0;
    endcase
  end

  assign sum_add = {1'b0, sum_e} + {17'h0, pts};
  assign sum_sat = sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];

  always_comb begin
    if (corrupt_e)
      status = ST_CORRUPT;
    else if (cnt_e != '0)
      status = ST_INCOMPLETE;
    else
      status = ST_VALID;
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    corrupt_nxt   = corrupt_r;
    bad_nxt       = bad_r;
    ovf_nxt       = ovf_r;
    sum_nxt       = sum_r;
    top_nxt       = top_r;
    mem_we        = 1'b0;
    wr_addr       = cnt_e[ADDR_W-1:0];
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    if (in_fire) begin
      cnt_nxt     = cnt_e;
      corrupt_nxt = corrupt_e;
      bad_nxt     = bad_e;
      ovf_nxt     = ovf_e;
      sum_nxt     = sum_e;
      if (ch != CH_NL) begin
        if (!corrupt_e) begin
          if (is_open) begin
            if (cnt_e < DEPTH_CNT) begin
              mem_we  = 1'b1;
              top_nxt = open_ty;
              cnt_nxt = cnt_e + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end else if (is_close && cnt_e != '0 && top_r == close_ty) begin
            // new top is the prefetched entry below the current one
            cnt_nxt = cnt_e - 1'b1;
            top_nxt = below_r;
          end else begin
            corrupt_nxt = 1'b1;
            bad_nxt     = ch;
          end
        end
      end else begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {5'h0, ovf_e,
                         corrupt_e ? sum_sat : sum_e,
                         corrupt_e ? pts : 16'h0,
                         corrupt_e ? bad_e : 8'h00,
                         status};
        sum_nxt     = corrupt_e ? sum_sat : sum_e;
        cnt_nxt     = '0;
        corrupt_nxt = 1'b0;
        bad_nxt     = 8'h00;
        ovf_nxt     = 1'b0;
      end
    end
  end

  // Prefetch the entry under next cycle's top; garbage when fewer than two entries
  assign rd_cnt  = cnt_nxt - CNT_W'(2);
  assign rd_addr = rd_cnt[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we)
      stack_mem[wr_addr] <= top_nxt;
    below_r <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      corrupt_r   <= 1'b0;
      bad_r       <= 8'h00;
      ovf_r       <= 1'b0;
      sum_r       <= 32'h0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      corrupt_r   <= corrupt_nxt;
      bad_r       <= bad_nxt;
      ovf_r       <= ovf_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_round_r  <= W_ROUND_RST;
      w_square_r <= W_SQUARE_RST;
      w_curly_r  <= W_CURLY_RST;
      w_angle_r  <= W_ANGLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_W_ROUND:  w_round_r  <= cfg_wdata;
        CFG_W_SQUARE: w_square_r <= cfg_wdata;
        CFG_W_CURLY:  w_curly_r  <= cfg_wdata;
        CFG_W_ANGLE:  w_angle_r  <= cfg_wdata;
        default:      ;
      endcase
    end
  end

endmodule

// File: verif/bsc_line_monitor.sv
`timescale 1ns / 1ps

// Watches the text and line-result channels of the bracket checker, predicts
// one line report per newline beat and compares reports in order.
module bsc_line_monitor import bsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // [7:0] char_in, [8] start_of_text
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_W-1:0]      out_tdata,  // [1:0] status, [9:2] char, [25:10] points,
                                            // [57:26] total, [58] overflow
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    reports_due
);

  typedef struct {
    line_status_t status;
    logic [7:0]   bad_char;
    logic [15:0]  points;
    logic [31:0]  total;
    logic         overflow;
  } line_report_t;

  line_report_t report_q[$];

  br_type_t     nest[STACK_DEPTH];
  int unsigned  depth;
  logic         corrupt;
  logic         overflowed;
  logic [7:0]   bad_char;
  logic [31:0]  score;
  logic [15:0]  weight[4];

  function automatic int opener_kind(input logic [7:0] c);
    case (c)
      CH_OPEN_R: return BR_ROUND;
      CH_OPEN_S: return BR_SQUARE;
      CH_OPEN_C: return BR_CURLY;
      CH_OPEN_A: return BR_ANGLE;
      default:   return -1;
    endcase
  endfunction

  function automatic int closer_kind(input logic [7:0] c);
    case (c)
      CH_CLOSE_R: return BR_ROUND;
      CH_CLOSE_S: return BR_SQUARE;
      CH_CLOSE_C: return BR_CURLY;
      CH_CLOSE_A: return BR_ANGLE;
      default:    return -1;
    endcase
  endfunction

  task automatic clear_line();
    depth      = 0;
    corrupt    = 1'b0;
    bad_char   = '0;
    overflowed = 1'b0;
  endtask

  task automatic take_char(input logic [7:0] c, input logic sot);
    int           ok;
    int           ck;
    line_report_t r;
    if (sot) begin
      clear_line();
      score = '0;
    end
    if (c != CH_NL) begin
      if (!corrupt) begin
        ok = opener_kind(c);
        ck = closer_kind(c);
        if (ok >= 0) begin
          if (depth < STACK_DEPTH) begin
            nest[depth] = br_type_t'(ok);
            depth++;
          end else begin
            overflowed = 1'b1;  // push dropped, line stays clean
          end
        end else if (ck >= 0 && depth > 0 && nest[depth-1] == br_type_t'(ck)) begin
          depth--;
        end else begin
          corrupt  = 1'b1;
          bad_char = c;
        end
      end
    end else begin
      r.bad_char = '0;
      r.points   = '0;
      if (corrupt) begin
        r.status   = ST_CORRUPT;
        r.bad_char = bad_char;
        ck = closer_kind(bad_char);
        if (ck >= 0) r.points = weight[ck];
        if (score > 32'hFFFF_FFFF - {16'd0, r.points}) score = '1;
        else score = score + r.points;
      end else if (depth != 0) begin
        r.status = ST_INCOMPLETE;
      end else begin
        r.status = ST_VALID;
      end
      r.total    = score;
      r.overflow = overflowed;
      report_q.push_back(r);
      clear_line();
    end
  endtask

  task automatic check_report(input logic [OUT_W-1:0] d);
    line_report_t e;
    if (report_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t: line result with none pending: %h", $realtime, d);
    end else begin
      e = report_q.pop_front();
      if (d[1:0] !== e.status || d[9:2] !== e.bad_char || d[25:10] !== e.points ||
          d[57:26] !== e.total || d[58] !== e.overflow) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: line result mismatch: exp st %0d ch %h pts %0d tot %0d ovf %b",
                   $realtime, e.status, e.bad_char, e.points, e.total, e.overflow);
          $display("  got st %0d ch %h pts %0d tot %0d ovf %b",
                   d[1:0], d[9:2], d[25:10], d[57:26], d[58]);
        end
      end
    end
  endtask

  initial begin
    mismatches  = 0;
    reports_due = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_line();
      score = '0;
      weight[CFG_W_ROUND]  = W_ROUND_RST;
      weight[CFG_W_SQUARE] = W_SQUARE_RST;
      weight[CFG_W_CURLY]  = W_CURLY_RST;
      weight[CFG_W_ANGLE]  = W_ANGLE_RST;
      report_q.delete();
    end else begin
      if (cfg_we) weight[cfg_addr] = cfg_wdata;
      // a newline beat reports in the following cycle at the earliest, so check first
      if (out_tvalid && out_tready) check_report(out_tdata);
      if (in_tvalid && in_tready) take_char(in_tdata[7:0], in_tdata[8]);
    end
    reports_due = report_q.size();
  end

endmodule

// File: verif/bracket_syntax_checker_test.sv
`timescale 1ns / 1ps

module bracket_syntax_checker_test;
  import bsc_pkg::*;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata   = '0;   // [7:0] char_in, [8] start_of_text
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;         // [1:0] status, [9:2] char, [25:10] points,
                                            // [57:26] total, [58] overflow
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  int mismatches;
  int reports_due;
  int in_idle_pct   = 0;
  int out_stall_pct = 0;

  localparam logic [7:0] OPEN_CH[4]  = '{CH_OPEN_R, CH_OPEN_S, CH_OPEN_C, CH_OPEN_A};
  localparam logic [7:0] CLOSE_CH[4] = '{CH_CLOSE_R, CH_CLOSE_S, CH_CLOSE_C, CH_CLOSE_A};

  logic [7:0] line_q[$];
  int         nest_q[$];
  int         line_useful;

  bracket_syntax_checker dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  bsc_line_monitor monitor (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_we, .cfg_addr, .cfg_wdata,
    .mismatches, .reports_due
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // entered and left at a falling edge
  task automatic send_char(input logic [7:0] c, input logic sot);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W-9){1'b0}}, sot, c};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic put_text(input string s, input logic sot_first);
    for (int i = 0; i < s.len(); i++) send_char(s[i], sot_first && i == 0);
    send_char(CH_NL, 1'b0);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (reports_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_weights(input logic [15:0] w0, input logic [15:0] w1,
                              input logic [15:0] w2, input logic [15:0] w3);
    logic [15:0] w[4];
    w = '{w0, w1, w2, w3};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= cfg_idx_t'(i);
      cfg_wdata <= w[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CH_NL);
    return c;
  endfunction

  function automatic bit is_opener(input logic [7:0] c);
    return c == CH_OPEN_R || c == CH_OPEN_S || c == CH_OPEN_C || c == CH_OPEN_A;
  endfunction

  // random nesting; nest_q holds the kinds still open
  task automatic add_brackets(input int n_open, input int max_depth, input bit close_all);
    int opened;
    int k;
    opened = 0;
    while (opened < n_open || (close_all && nest_q.size() > 0)) begin
      if (opened < n_open &&
          (nest_q.size() == 0 || (nest_q.size() < max_depth && $urandom_range(1)))) begin
        k = $urandom_range(3);
        nest_q.push_back(k);
        line_q.push_back(OPEN_CH[k]);
        opened++;
      end else begin
        line_q.push_back(CLOSE_CH[nest_q.pop_back()]);
      end
    end
  endtask

  task automatic build_line();
    int         mode;
    int         k;
    logic [7:0] c;
    line_q.delete();
    nest_q.delete();
    mode = $urandom_range(99);
    if (mode < 35) begin
      add_brackets($urandom_range(10), $urandom_range(1, 8), 1'b1);
    end else if (mode < 60) begin
      add_brackets($urandom_range(10), $urandom_range(1, 8), 1'b0);
      repeat ($urandom_range(1, 3)) line_q.push_back(OPEN_CH[$urandom_range(3)]);
    end else if (mode < 85) begin
      add_brackets($urandom_range(8), $urandom_range(1, 6), 1'b0);
      k = $urandom_range(2);
      if (k == 0 && nest_q.size() > 0) begin
        line_q.push_back(CLOSE_CH[(nest_q[$] + $urandom_range(1, 3)) % 4]);
      end else if (k == 1) begin
        line_q.push_back(CLOSE_CH[$urandom_range(3)]);
      end else begin
        do c = text_byte(); while (is_opener(c));
        line_q.push_back(c);
      end
    end else if (mode < 95) begin
      repeat ($urandom_range(10)) line_q.push_back(text_byte());
    end else begin
      // deep nesting around the stack limit
      add_brackets($urandom_range(STACK_DEPTH - 8, STACK_DEPTH + 7), 2 * STACK_DEPTH,
                   1'($urandom_range(1)));
    end
    line_useful = line_q.size() + 1;
    // tail of a corrupt line is ignored by the block
    if (mode >= 60 && mode < 85)
      repeat ($urandom_range(6)) line_q.push_back(text_byte());
    line_q.push_back(CH_NL);
  endtask

  task automatic random_text(input int n_items);
    int sent;
    int sot_at;
    sent = 0;
    while (sent < n_items) begin
      build_line();
      sot_at = ($urandom_range(99) < 3) ? $urandom_range(line_q.size() - 1) : -1;
      foreach (line_q[i]) send_char(line_q[i], i == sot_at);
      sent += line_useful;
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed lines at reset weights
    send_char(CH_NL, 1'b0);
    put_text("([{<>}])", 1'b0);
    send_char(CH_OPEN_R, 1'b0);
    send_char(CH_CLOSE_S, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(CH_NL, 1'b0);
    put_text(")", 1'b0);
    put_text("{>", 1'b0);
    put_text("<}", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_NL, 1'b0);
    put_text("((", 1'b0);
    put_text("[", 1'b1);
    settle();

    // run of corrupt lines at full weight
    load_weights(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 40; i++) begin
      send_char(CLOSE_CH[$urandom_range(3)], i == 0);
      send_char(CH_NL, 1'b0);
    end
    settle();

    load_weights(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_text(400);
    settle();

    load_weights(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    in_idle_pct = 87;
    random_text(400);
    settle();

    load_weights(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    in_idle_pct   = 0;
    out_stall_pct = 87;
    random_text(400);
    settle();

    load_weights(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    in_idle_pct   = 10;
    out_stall_pct = 10;
    random_text(400);
    settle();

    if (mismatches == 0 && reports_due == 0) begin
      $display("bracket_syntax_checker_test: PASS");
    end else begin
      $display("bracket_syntax_checker_test: FAIL");
    end
    $finish;
  end

  initial begin
    #(4_000_000);
    $display("bracket_syntax_checker_test: FAIL");
    $finish;
  end

endmodule
